### hw/rtl/dbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbd_pkg
// shared types, constants and small tables for the day number pipeline
// ----------------------------------------------------------------------------
package dbd_pkg;

    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned JdnW    = 23;
    localparam int unsigned DiffW   = 22;
    localparam int unsigned ShYearW = 15;

    localparam int unsigned YearMax  = 9999;
    localparam int unsigned YearBias = 4800;
    localparam int unsigned JdnBias  = 32045;
    localparam int unsigned DaysYear = 365;

    // floor(x / 100) as (x * Recip100) >> Recip100Sh, exact for x below 2^15
    localparam int unsigned Recip100   = 5243;
    localparam int unsigned Recip100Sh = 19;

    // register stages inside one date unit
    localparam int unsigned DateLat = 3;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FIRST_BAD  = 2'd1,
        STAT_SECOND_BAD = 2'd2
    } t_status;

    typedef struct packed {
        logic            ok;
        logic [JdnW-1:0] jdn;
    } t_date_res;

    // days in month, february as 28
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (153 * ms + 2) / 5 for the march-based month index
    function automatic logic [8:0] month_off(input logic [MonthW-1:0] ms);
        logic [8:0] off;
        unique case (ms)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/dbd_date_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbd_date_unit
// three-stage check and julian day number of one gregorian date
// ----------------------------------------------------------------------------
module dbd_date_unit
    import dbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [YearW-1:0]  i_year,
    input  wire logic [MonthW-1:0] i_month,
    input  wire logic [DayW-1:0]   i_day,
    output t_date_res              o_res
);

    // stage 1
    logic                early;
    logic [ShYearW-1:0]  ys;
    logic [MonthW-1:0]   ms;
    logic [YearW+12:0]   y_prod;
    logic [ShYearW+12:0] ys_prod;
    logic                rng_ok;

    logic                r1_rng_ok;
    logic                r1_feb;
    logic [DayW-1:0]     r1_lim;
    logic [DayW-1:0]     r1_day;
    logic [YearW-1:0]    r1_year;
    logic [7:0]          r1_yq;
    logic [ShYearW-1:0]  r1_ys;
    logic [8:0]          r1_ysq;
    logic [MonthW-1:0]   r1_ms;

    always_comb begin
        early   = (i_month <= 4'd2);
        ys      = {1'b0, i_year} + ShYearW'(YearBias) - ShYearW'(early);
        ms      = i_month + (early ? 4'd12 : 4'd0) - 4'd3;
        y_prod  = (YearW+13)'(i_year) * (YearW+13)'(Recip100);
        ys_prod = (ShYearW+13)'(ys) * (ShYearW+13)'(Recip100);
        rng_ok  = (i_year >= 14'd1) && (i_year <= YearW'(YearMax))
                  && (i_month >= 4'd1) && (i_month <= 4'd12) && (i_day >= 5'd1);
    end

    always_ff @(posedge i_clk) begin
        r1_rng_ok <= rng_ok;
        r1_feb    <= (i_month == 4'd2);
        r1_lim    <= month_len(i_month);
        r1_day    <= i_day;
        r1_year   <= i_year;
        r1_yq     <= y_prod[Recip100Sh +: 8];
        r1_ys     <= ys;
        r1_ysq    <= ys_prod[Recip100Sh +: 9];
        r1_ms     <= ms;
    end

    // stage 2
    logic [YearW-1:0]  rem100;
    logic              cent;
    logic              leap;
    logic [DayW-1:0]   lim;
    logic [8:0]        part_a;
    logic [JdnW-1:0]   part_b;
    logic [12:0]       part_c;

    logic              r2_ok;
    logic [8:0]        r2_a;
    logic [JdnW-1:0]   r2_b;
    logic [12:0]       r2_c;

    always_comb begin
        rem100 = r1_year - YearW'(15'(r1_yq) * 15'd100);
        cent   = (rem100 == '0);
        leap   = ((r1_year[1:0] == 2'd0) && !cent) || (cent && (r1_yq[1:0] == 2'd0));
        lim    = (r1_feb && leap) ? 5'd29 : r1_lim;
        part_a = 9'(r1_day) + month_off(r1_ms);
        part_b = JdnW'(24'(r1_ys) * 24'(DaysYear));
        part_c = 13'(r1_ys >> 2) - 13'(r1_ysq) + 13'(r1_ysq >> 2);
    end

    always_ff @(posedge i_clk) begin
        r2_ok <= r1_rng_ok && (r1_day <= lim);
        r2_a  <= part_a;
        r2_b  <= part_b;
        r2_c  <= part_c;
    end

    // stage 3
    logic            r3_ok;
    logic [JdnW-1:0] r3_jdn;

    always_ff @(posedge i_clk) begin
        r3_ok  <= r2_ok;
        r3_jdn <= r2_b + JdnW'(r2_a) + JdnW'(r2_c) - JdnW'(JdnBias);
    end

    assign o_res.ok  = r3_ok;
    assign o_res.jdn = r3_jdn;

endmodule
`default_nettype wire

### hw/rtl/days_between_dates_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// days_between_dates_top
// validates two gregorian dates and reports their day numbers and distance
// ----------------------------------------------------------------------------
// One date pair is taken on every clock edge where start is high; busy is
// never raised. Each pair yields one word on the result ports, marked by a
// one-cycle o_done, after three stages per date unit (range and division by
// 100, leap check and partial terms, final sum) and one stage for the
// difference and status. The receiver cannot stall, so the pipeline simply
// flows. On an invalid date the status names the first failing date and all
// numeric outputs are zero.
module days_between_dates_top
    import dbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [YearW-1:0]  i_year_first,
    input  wire logic [MonthW-1:0] i_month_first,
    input  wire logic [DayW-1:0]   i_day_first,
    input  wire logic [YearW-1:0]  i_year_second,
    input  wire logic [MonthW-1:0] i_month_second,
    input  wire logic [DayW-1:0]   i_day_second,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [JdnW-1:0]        o_day_number_first,
    output logic [JdnW-1:0]        o_day_number_second,
    output logic [DiffW-1:0]       o_days_apart
);

    t_date_res           res_first;
    t_date_res           res_second;
    logic [DateLat-1:0]  r_vld;
    logic                accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    dbd_date_unit u_first (
        .i_clk   (i_clk),
        .i_year  (i_year_first),
        .i_month (i_month_first),
        .i_day   (i_day_first),
        .o_res   (res_first)
    );

    dbd_date_unit u_second (
        .i_clk   (i_clk),
        .i_year  (i_year_second),
        .i_month (i_month_second),
        .i_day   (i_day_second),
        .o_res   (res_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DateLat-2:0], accept};
        end
    end

    // difference and status stage
    t_status         status;
    logic [JdnW-1:0] diff;

    always_comb begin
        diff = (res_second.jdn >= res_first.jdn) ? (res_second.jdn - res_first.jdn)
                                                 : (res_first.jdn - res_second.jdn);
        priority if (!res_first.ok) begin
            status = STAT_FIRST_BAD;
        end else if (!res_second.ok) begin
            status = STAT_SECOND_BAD;
        end else begin
            status = STAT_OK;
        end
    end

    logic                r_done;
    t_status             r_status;
    logic [JdnW-1:0]     r_jdn_first;
    logic [JdnW-1:0]     r_jdn_second;
    logic [DiffW-1:0]    r_apart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[DateLat-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= status;
        if (status == STAT_OK) begin
            r_jdn_first  <= res_first.jdn;
            r_jdn_second <= res_second.jdn;
            r_apart      <= diff[DiffW-1:0];
        end else begin
            r_jdn_first  <= '0;
            r_jdn_second <= '0;
            r_apart      <= '0;
        end
    end

    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_day_number_first  = r_jdn_first;
    assign o_day_number_second = r_jdn_second;
    assign o_days_apart        = r_apart;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_done)
        else $error("accepted word did not produce a result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 4))
        else $error("result strobe without a matching accepted word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == STAT_OK || o_status == STAT_FIRST_BAD
                    || o_status == STAT_SECOND_BAD))
        else $error("undefined status code on result");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STAT_OK) |-> (o_day_number_first == '0
            && o_day_number_second == '0 && o_days_apart == '0))
        else $error("invalid date result carries nonzero numbers");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");
`endif

endmodule
`default_nettype wire
